[design/vhcp_pkg.sv]
// ----------------------------------------------------------------------------
// vhcp_pkg
// Shared types and constants of the video header and caption parser.
// ----------------------------------------------------------------------------
`default_nettype none

package vhcp_pkg;

  localparam logic [23:0] START_CODE     = 24'h000001;
  localparam logic [7:0]  CODE_PICTURE   = 8'h00;
  localparam logic [7:0]  CODE_USER_DATA = 8'hB2;
  localparam logic [7:0]  CODE_SEQUENCE  = 8'hB3;
  localparam logic [7:0]  CODE_GOP       = 8'hB8;
  localparam logic [31:0] ATSC_ID        = 32'h47413934;
  localparam logic [7:0]  USER_TYPE_CC   = 8'h03;

  localparam logic [1:0] KIND_GOP      = 2'd0;
  localparam logic [1:0] KIND_SEQUENCE = 2'd1;
  localparam logic [1:0] KIND_PICTURE  = 2'd2;
  localparam logic [1:0] KIND_CAPTION  = 2'd3;

  localparam logic [2:0] CLASS_NONE     = 3'd0;
  localparam logic [2:0] CLASS_TEXT     = 3'd1;
  localparam logic [2:0] CLASS_PREAMBLE = 3'd2;
  localparam logic [2:0] CLASS_MISC     = 3'd3;
  localparam logic [2:0] CLASS_TAB      = 3'd4;

  typedef enum logic [3:0] {
    PH_SCAN,
    PH_CODE,
    PH_GOP,
    PH_SEQ,
    PH_PIC,
    PH_USR_ID,
    PH_USR_TYPE,
    PH_USR_COUNT,
    PH_USR_RSV,
    PH_PAIR
  } phase_e;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [31:0] position;
    logic        flag_a;
    logic        flag_b;
    logic        flag_c;
    logic [11:0] value_a;
    logic [11:0] value_b;
    logic [5:0]  value_c;
    logic [5:0]  value_d;
    logic [2:0]  caption_class;
    logic [3:0]  command_code;
  } result_t;

endpackage

`default_nettype wire

[design/vhcp_classify.sv]
// ----------------------------------------------------------------------------
// vhcp_classify
// CEA-608 classification of one parity-stripped caption byte pair.
// ----------------------------------------------------------------------------
`default_nettype none

module vhcp_classify (
  input  wire logic [6:0] hi_i,
  input  wire logic [6:0] lo_i,
  output logic      [2:0] class_o,
  output logic      [3:0] code_o
);
  import vhcp_pkg::*;

  logic [6:0] hi_f;

  always_comb begin
    hi_f = hi_i;
    if (hi_i inside {[7'h18:7'h1F]}) begin
      hi_f = hi_i - 7'd8;
    end
    class_o = CLASS_NONE;
    code_o  = 4'd0;
    if (hi_f >= 7'h20) begin
      class_o = CLASS_TEXT;
    end else if ((hi_f inside {[7'h11:7'h17]} && lo_i >= 7'h40) ||
                 (hi_f == 7'h10 && lo_i inside {[7'h40:7'h5F]})) begin
      class_o = CLASS_PREAMBLE;
    end else if (hi_f inside {[7'h14:7'h15]} && lo_i inside {[7'h20:7'h2F]}) begin
      class_o = CLASS_MISC;
      code_o  = lo_i[3:0];
    end else if (hi_f == 7'h17 && lo_i inside {[7'h21:7'h23]}) begin
      class_o = CLASS_TAB;
      code_o  = lo_i[3:0];
    end
  end

endmodule

`default_nettype wire

[design/vhcp_parser.sv]
// ----------------------------------------------------------------------------
// vhcp_parser
// Start code search, header field and caption pair extraction, one byte per strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module vhcp_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        byte_i,
  input  wire logic [1:0]        type_sel_i,
  output logic                   emit_o,
  output vhcp_pkg::result_t      result_o
);
  import vhcp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [23:0] recent_q, recent_d;
  logic [2:0]  count_q, count_d;
  logic [31:0] acc_q, acc_d;
  logic [4:0]  pairs_q, pairs_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] start_q, start_d;

  logic [31:0] a;
  logic [2:0]  count_inc;
  logic [4:0]  pairs_dec;
  logic [2:0]  cls;
  logic [3:0]  code;

  assign a         = {acc_q[23:0], byte_i};
  assign count_inc = count_q + 3'd1;
  assign pairs_dec = pairs_q - 5'd1;

  vhcp_classify u_classify (
    .hi_i   (a[14:8]),
    .lo_i   (a[6:0]),
    .class_o(cls),
    .code_o (code)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SCAN;
      recent_q <= '0;
      count_q  <= '0;
      acc_q    <= '0;
      pairs_q  <= '0;
      pos_q    <= '0;
      start_q  <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      recent_q <= recent_d;
      count_q  <= count_d;
      acc_q    <= acc_d;
      pairs_q  <= pairs_d;
      pos_q    <= pos_d;
      start_q  <= start_d;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    recent_d = {recent_q[15:0], byte_i};
    count_d  = count_q;
    acc_d    = a;
    pairs_d  = pairs_q;
    pos_d    = pos_q + 32'd1;
    start_d  = start_q;
    emit_o   = 1'b0;
    result_o = '0;
    result_o.position = start_q;

    case (phase_q)
      PH_SCAN: begin
        if (recent_d == START_CODE) begin
          start_d = pos_q - 32'd2;
          phase_d = PH_CODE;
        end
      end
      PH_CODE: begin
        count_d = '0;
        acc_d   = '0;
        case (byte_i)
          CODE_PICTURE:   phase_d = PH_PIC;
          CODE_USER_DATA: phase_d = PH_USR_ID;
          CODE_SEQUENCE:  phase_d = PH_SEQ;
          CODE_GOP:       phase_d = PH_GOP;
          default:        phase_d = PH_SCAN;
        endcase
      end
      PH_GOP: begin
        count_d = count_inc;
        if (count_inc >= 3'd4) begin
          phase_d              = PH_SCAN;
          emit_o               = 1'b1;
          result_o.record_kind = KIND_GOP;
          result_o.flag_a      = a[31];
          result_o.flag_b      = a[6];
          result_o.flag_c      = a[5];
          result_o.value_a     = {7'd0, a[30:26]};
          result_o.value_b     = {6'd0, a[25:20]};
          result_o.value_c     = a[18:13];
          result_o.value_d     = a[12:7];
        end
      end
      PH_SEQ: begin
        count_d = count_inc;
        if (count_inc >= 3'd4) begin
          phase_d              = PH_SCAN;
          emit_o               = 1'b1;
          result_o.record_kind = KIND_SEQUENCE;
          result_o.value_a     = a[31:20];
          result_o.value_b     = a[19:8];
          result_o.value_c     = {2'd0, a[7:4]};
          result_o.value_d     = {2'd0, a[3:0]};
        end
      end
      PH_PIC: begin
        count_d = count_inc;
        if (count_inc >= 3'd2) begin
          phase_d              = PH_SCAN;
          emit_o               = 1'b1;
          result_o.record_kind = KIND_PICTURE;
          result_o.value_a     = {2'd0, a[15:6]};
          result_o.value_c     = {3'd0, a[5:3]};
        end
      end
      PH_USR_ID: begin
        count_d = count_inc;
        if (count_inc >= 3'd4) begin
          phase_d = (a == ATSC_ID) ? PH_USR_TYPE : PH_SCAN;
        end
      end
      PH_USR_TYPE: begin
        phase_d = (byte_i == USER_TYPE_CC) ? PH_USR_COUNT : PH_SCAN;
      end
      PH_USR_COUNT: begin
        pairs_d = byte_i[4:0];
        phase_d = PH_USR_RSV;
      end
      PH_USR_RSV: begin
        count_d = '0;
        phase_d = (pairs_q == 5'd0) ? PH_SCAN : PH_PAIR;
      end
      PH_PAIR: begin
        count_d = count_inc;
        if (count_inc >= 3'd3) begin
          count_d = '0;
          pairs_d = pairs_dec;
          if (pairs_dec == 5'd0) begin
            phase_d = PH_SCAN;
          end
          if (a[17:16] == type_sel_i) begin
            emit_o                 = 1'b1;
            result_o.record_kind   = KIND_CAPTION;
            result_o.flag_a        = a[18];
            result_o.value_a       = {5'd0, a[14:8]};
            result_o.value_b       = {5'd0, a[6:0]};
            result_o.value_c       = {4'd0, a[17:16]};
            result_o.caption_class = cls;
            result_o.command_code  = code;
          end
        end
      end
      default: begin
        phase_d = PH_SCAN;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/video_header_caption_parser_unit.sv]
// ----------------------------------------------------------------------------
// video_header_caption_parser_unit
// MPEG-2 video header and CEA-608 caption pair parser with stream ports.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock with no gaps under continuous traffic,
// unless m_axis_tready holds back a pending result. Each byte passes an
// input register and the parse logic, and its record, if any, lands in
// the output register. Throughput is set by the single-byte parse step.
`default_nettype none

module video_header_caption_parser_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_data_i,    // caption_type_select
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // stream_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // position, flag_a, flag_b, flag_c, value_a, value_b, value_c, value_d,
  // caption_class, command_code, zero pad
  output logic [79:0]      m_axis_tdata,
  output logic [1:0]       m_axis_tuser   // record_kind
);
  import vhcp_pkg::*;

  logic [1:0] type_sel_q;
  logic [1:0] type_sel_d;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  result_t    out_q;
  logic       step;
  logic       emit;
  result_t    result;

  assign cfg_ready_o   = 1'b1;
  assign type_sel_d    = cfg_data_i;
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_sel_q <= 2'd0;
    end else if (cfg_valid_i) begin
      type_sel_q <= type_sel_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  vhcp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (in_byte_q),
    .type_sel_i(type_sel_q),
    .emit_o    (emit),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= emit;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.record_kind;
  assign m_axis_tdata  = {2'b00, out_q.command_code, out_q.caption_class,
                          out_q.value_d, out_q.value_c, out_q.value_b,
                          out_q.value_a, out_q.flag_c, out_q.flag_b,
                          out_q.flag_a, out_q.position};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input register empty but not ready");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(in_valid_q))
    else $error("result without a buffered byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != KIND_CAPTION) |->
      (out_q.caption_class == CLASS_NONE && out_q.command_code == 4'd0))
    else $error("header record carries caption class");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_q.caption_class == CLASS_NONE ||
                       out_q.caption_class == CLASS_TEXT ||
                       out_q.caption_class == CLASS_PREAMBLE)) |->
      out_q.command_code == 4'd0)
    else $error("command code set for class without code");

endmodule

`default_nettype wire
